[hdl/gsmf_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gsmf_pkg
// Types, register map and gear table shared by the sub-chunk feature extractor.
// ----------------------------------------------------------------------------
package gsmf_pkg;

    localparam int DATA_W  = 64;
    localparam int INDEX_W = 5;
    localparam int MAXF_W  = 6;
    localparam int ADDR_W  = 5;

    // register indexes (paddr[4:3])
    localparam logic [1:0] REG_BOUNDARY_MASK = 2'd0;
    localparam logic [1:0] REG_FEATURE_MASK  = 2'd1;
    localparam logic [1:0] REG_MAX_FEATURES  = 2'd2;

    localparam logic [DATA_W-1:0] BOUNDARY_MASK_RESET = 64'h0000_5900_0300_0000;
    localparam logic [DATA_W-1:0] FEATURE_MASK_RESET  = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [MAXF_W-1:0] MAX_FEATURES_RESET  = 6'd32;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_LVL_W = 3;

    typedef struct packed {
        logic [DATA_W-1:0]  value;
        logic [INDEX_W-1:0] index;
        logic               last;
    } result_t;

    typedef logic [63:0] gear_table_t [256];

    localparam logic [31:0] MD5_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam int MD5_S [16] = '{7, 12, 17, 22, 5, 9, 14, 20,
                                  4, 11, 16, 23, 6, 10, 15, 21};

    // one MD5 compression; words are little endian within blk
    function automatic logic [127:0] md5_block(input logic [127:0] st,
                                               input logic [511:0] blk);
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        logic [31:0] f;
        logic [31:0] tmp;
        int          g;
        int          sh;
        int          i;
        a = st[31:0];
        b = st[63:32];
        c = st[95:64];
        d = st[127:96];
        for (i = 0; i < 64; i++)
        begin
            if (i < 16)
            begin
                f = (b & c) | (~b & d);
                g = i;
            end
            else if (i < 32)
            begin
                f = (d & b) | (~d & c);
                g = (5 * i + 1) & 15;
            end
            else if (i < 48)
            begin
                f = b ^ c ^ d;
                g = (3 * i + 5) & 15;
            end
            else
            begin
                f = c ^ (b | ~d);
                g = (7 * i) & 15;
            end
            sh  = MD5_S[((i >> 4) << 2) | (i & 3)];
            f   = f + a + MD5_K[i] + blk[32*g +: 32];
            a   = d;
            d   = c;
            c   = b;
            tmp = (f << sh) | (f >> (32 - sh));
            b   = b + tmp;
        end
        return {st[127:96] + d, st[95:64] + c, st[63:32] + b, st[31:0] + a};
    endfunction

    // word v: low 8 bytes of MD5 over 64 bytes of value v
    function automatic gear_table_t build_gear_table();
        gear_table_t  t;
        logic [127:0] st;
        logic [511:0] blk;
        int           v;
        for (v = 0; v < 256; v++)
        begin
            st  = 128'h10325476_98badcfe_efcdab89_67452301;
            blk = {64{8'(v)}};
            st  = md5_block(st, blk);
            blk = '0;
            blk[7:0]     = 8'h80;
            blk[463:456] = 8'h02;   // length 512 bits
            st   = md5_block(st, blk);
            t[v] = st[63:0];
        end
        return t;
    endfunction

    localparam gear_table_t GEAR_TABLE = build_gear_table();

endpackage
`default_nettype wire

[hdl/gsmf_result_fifo.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gsmf_result_fifo
// Small result queue; takes up to two results per cycle, gives one.
// ----------------------------------------------------------------------------
module gsmf_result_fifo
    import gsmf_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [1:0]            push_num,
    input  wire result_t               push_data0,
    input  wire result_t               push_data1,
    input  wire logic                  pop,
    output result_t                    head,
    output logic [FIFO_LVL_W-1:0]      level
);

    result_t                  mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]    wr_ptr_reg;
    logic [FIFO_PTR_W-1:0]    wr_ptr_next;
    logic [FIFO_PTR_W-1:0]    rd_ptr_reg;
    logic [FIFO_PTR_W-1:0]    rd_ptr_next;
    logic [FIFO_LVL_W-1:0]    level_reg;
    logic [FIFO_LVL_W-1:0]    level_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + FIFO_PTR_W'(push_num);
        rd_ptr_next = rd_ptr_reg + FIFO_PTR_W'(pop);
        level_next  = level_reg + FIFO_LVL_W'(push_num) - FIFO_LVL_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_num != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push_data0;
        end
        if (push_num == 2'd2)
        begin
            mem_reg[wr_ptr_reg + FIFO_PTR_W'(1)] <= push_data1;
        end
    end

    assign head  = mem_reg[rd_ptr_reg];
    assign level = level_reg;

endmodule
`default_nettype wire

[hdl/gear_subchunk_max_features.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gear_subchunk_max_features
// Gear-hash sub-chunk feature extractor: rolls a 64-bit gear hash per byte
// and emits the masked running maximum at sub-chunk boundaries and chunk end.
// ----------------------------------------------------------------------------
// Path: an accepted item passes the input register, then the result queue.
// Throughput: one item per cycle while in_stall is low; the hash update,
// table read and max compare sit in one stage. An item may give two results;
// they leave one at a time, absorbed by a 4-entry result queue.
// Reset: async active low; registers back to defaults, hash/max/count cleared.
// ----------------------------------------------------------------------------
module gear_subchunk_max_features
    import gsmf_pkg::*;
#(
    parameter int MAX_FEATURE_SLOTS = 32
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,

    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [ADDR_W-1:0]  paddr,
    input  wire logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]       prdata,
    output logic                    pready,

    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [7:0]         data_byte,
    input  wire logic               chunk_end,

    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [DATA_W-1:0]       feature_value,
    output logic [INDEX_W-1:0]      feature_index,
    output logic                    final_feature
);

    localparam int CNT_W = $clog2(MAX_FEATURE_SLOTS + 1);

    // configuration
    logic [DATA_W-1:0]  boundary_mask_reg;
    logic [DATA_W-1:0]  feature_mask_reg;
    logic [MAXF_W-1:0]  max_features_reg;
    logic               cfg_write;

    // input register
    logic               in_valid_reg;
    logic [7:0]         in_byte_reg;
    logic               in_end_reg;

    // chunk state
    logic [DATA_W-1:0]  hash_reg;
    logic [DATA_W-1:0]  hash_next;
    logic [DATA_W-1:0]  max_reg;
    logic [DATA_W-1:0]  max_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    logic [6:0]         limit_wide;
    logic [CNT_W-1:0]   limit;
    logic               active;
    logic [DATA_W-1:0]  hash_roll;
    logic [DATA_W-1:0]  masked;
    logic [DATA_W-1:0]  max_upd;
    logic               boundary;
    logic [CNT_W-1:0]   count_inc;
    logic [CNT_W-1:0]   count_after;
    logic [DATA_W-1:0]  max_after;

    logic               fire;
    logic               pop;
    logic [FIFO_LVL_W-1:0] level;
    logic [FIFO_LVL_W-1:0] level_after_pop;
    logic [1:0]         push_num;
    result_t            push_data0;
    result_t            push_data1;
    result_t            head;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            boundary_mask_reg <= BOUNDARY_MASK_RESET;
            feature_mask_reg  <= FEATURE_MASK_RESET;
            max_features_reg  <= MAX_FEATURES_RESET;
        end
        else if (cfg_write)
        begin
            case (paddr[4:3])
                REG_BOUNDARY_MASK: boundary_mask_reg <= pwdata;
                REG_FEATURE_MASK:  feature_mask_reg  <= pwdata;
                REG_MAX_FEATURES:  max_features_reg  <= pwdata[MAXF_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:3])
            REG_BOUNDARY_MASK: prdata = boundary_mask_reg;
            REG_FEATURE_MASK:  prdata = feature_mask_reg;
            REG_MAX_FEATURES:  prdata = DATA_W'(max_features_reg);
            default:           prdata = '0;
        endcase
    end

    // ---------------- input register ----------------
    assign level_after_pop = level - FIFO_LVL_W'(pop);
    // need room for two results before taking the registered item
    assign fire     = in_valid_reg && (level_after_pop <= FIFO_LVL_W'(FIFO_DEPTH - 2));
    assign in_stall = in_valid_reg && !fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_byte_reg <= data_byte;
            in_end_reg  <= chunk_end;
        end
    end

    // ---------------- hash / feature stage ----------------
    always_comb
    begin
        // zero counts as one, above the slot count saturates
        if (max_features_reg == '0)
        begin
            limit_wide = 7'd1;
        end
        else if (7'(max_features_reg) > 7'(MAX_FEATURE_SLOTS))
        begin
            limit_wide = 7'(MAX_FEATURE_SLOTS);
        end
        else
        begin
            limit_wide = 7'(max_features_reg);
        end
        limit = CNT_W'(limit_wide);

        active    = count_reg < limit;
        hash_roll = (hash_reg << 1) + GEAR_TABLE[in_byte_reg];
        masked    = hash_roll & feature_mask_reg;
        max_upd   = (masked > max_reg) ? masked : max_reg;
        boundary  = (hash_roll & boundary_mask_reg) == '0;
        count_inc = count_reg + CNT_W'(1);

        count_after = boundary ? count_inc : count_reg;
        max_after   = boundary ? '0 : max_upd;

        push_data0.value = max_upd;
        push_data0.index = INDEX_W'(7'(count_reg));
        push_data0.last  = count_inc >= limit;
        push_data1.value = max_after;
        push_data1.index = INDEX_W'(7'(count_after));
        push_data1.last  = 1'b1;
        push_num         = 2'd0;

        if (fire && active)
        begin
            if (boundary)
            begin
                push_num = (in_end_reg && count_after < limit) ? 2'd2 : 2'd1;
            end
            else if (in_end_reg)
            begin
                // only the open maximum goes out
                push_num   = 2'd1;
                push_data0 = push_data1;
            end
        end

        hash_next  = hash_reg;
        max_next   = max_reg;
        count_next = count_reg;
        if (fire)
        begin
            if (in_end_reg)
            begin
                hash_next  = '0;
                max_next   = '0;
                count_next = '0;
            end
            else if (active)
            begin
                hash_next  = hash_roll;
                max_next   = max_after;
                count_next = count_after;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg  <= '0;
            max_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            hash_reg  <= hash_next;
            max_reg   <= max_next;
            count_reg <= count_next;
        end
    end

    // ---------------- result queue ----------------
    assign out_valid = level != '0;
    assign pop       = out_valid && !out_stall;

    gsmf_result_fifo u_result_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_num   (push_num),
        .push_data0 (push_data0),
        .push_data1 (push_data1),
        .pop        (pop),
        .head       (head),
        .level      (level)
    );

    assign feature_value = head.value;
    assign feature_index = head.index;
    assign final_feature = head.last;

endmodule
`default_nettype wire
